// ===== hdl/tcpg_pkg.sv =====
`default_nettype none

package tcpg_pkg;

  // field widths
  localparam int unsigned TEMP_W = 18;
  localparam int unsigned CPU_W  = 11;
  localparam int unsigned GPU_W  = 10;
  localparam int unsigned MEM_W  = 11;
  localparam int unsigned MHZ_W  = 11;  // widest clock field, used for the applied store
  localparam int unsigned NUM_MOD = 3;

  // apb register map
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_PROFILE    = 2'd0;
  localparam logic [1:0] REG_NEWER_CHIP = 2'd1;
  localparam logic [1:0] REG_GUARD_ENTER = 2'd2;
  localparam logic [1:0] REG_GUARD_EXIT  = 2'd3;

  localparam logic [TEMP_W-1:0] GUARD_ENTER_RST = 18'd75000;
  localparam logic [TEMP_W-1:0] GUARD_EXIT_RST  = 18'd70000;

  // clock profiles
  localparam logic [1:0] PROF_STOCK    = 2'd0;
  localparam logic [1:0] PROF_BALANCED = 2'd1;
  localparam logic [1:0] PROF_PERF     = 2'd2;
  localparam logic [1:0] PROF_MAX      = 2'd3;

  // power modes
  localparam logic [2:0] MODE_HANDHELD = 3'd0;
  localparam logic [2:0] MODE_CHARGING = 3'd1;
  localparam logic [2:0] MODE_USB      = 3'd2;
  localparam logic [2:0] MODE_OFFICIAL = 3'd3;
  localparam logic [2:0] MODE_DOCKED   = 3'd4;

  // clock table entries in MHz
  localparam logic [CPU_W-1:0] CPU_STOCK_MHZ = 11'd1020;
  localparam logic [CPU_W-1:0] CPU_1224_MHZ  = 11'd1224;
  localparam logic [CPU_W-1:0] CPU_1428_MHZ  = 11'd1428;
  localparam logic [CPU_W-1:0] CPU_1581_MHZ  = 11'd1581;
  localparam logic [CPU_W-1:0] CPU_1785_MHZ  = 11'd1785;
  localparam logic [GPU_W-1:0] GPU_STOCK_MHZ = 10'd384;
  localparam logic [GPU_W-1:0] GPU_DOCK_MHZ  = 10'd768;
  localparam logic [GPU_W-1:0] GPU_BAL_DOCK_MHZ = 10'd691;
  localparam logic [GPU_W-1:0] GPU_CAP_NEW_MHZ  = 10'd614;
  localparam logic [GPU_W-1:0] GPU_CAP_OLD_MHZ  = 10'd460;
  localparam logic [MEM_W-1:0] MEM_STOCK_MHZ = 11'd1331;
  localparam logic [MEM_W-1:0] MEM_FULL_MHZ  = 11'd1600;

  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_GUARD_ENTER = 3'd1,
    ST_RECOVERED   = 3'd2,
    ST_WRITE_FAIL  = 3'd3,
    ST_LINK_LOST   = 3'd4
  } status_e;

  typedef struct packed {
    logic              link_ok;
    logic [2:0]        power_mode;
    logic [TEMP_W-1:0] temp_soc;
    logic [TEMP_W-1:0] temp_board;
    logic [TEMP_W-1:0] temp_skin;
    logic [2:0]        fail_mask;
  } tcpg_in_t;

  typedef struct packed {
    logic [CPU_W-1:0]  cpu_target_mhz;
    logic [GPU_W-1:0]  gpu_target_mhz;
    logic [MEM_W-1:0]  mem_target_mhz;
    logic [2:0]        write_mask;
    logic              guard_active;
    logic [TEMP_W-1:0] hottest_millic;
    status_e           status_code;
  } tcpg_out_t;

  typedef struct packed {
    logic [1:0]        profile_select;
    logic              newer_chip;
    logic [TEMP_W-1:0] guard_enter_millic;
    logic [TEMP_W-1:0] guard_exit_millic;
  } cfg_t;

  typedef struct packed {
    logic                            guard_flag;
    logic [NUM_MOD-1:0][MHZ_W-1:0]   applied_mhz;
  } state_t;

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic [GPU_W-1:0] gpu;
    logic [MEM_W-1:0] mem;
  } mhz_t;

  // clock table: profile x power mode x chip variant
  function automatic mhz_t pick_targets(input logic [1:0] prof, input logic [2:0] pmode,
                                        input logic newer);
    mhz_t       t;
    logic       docked;
    logic       official;
    logic       charging;
    logic [GPU_W-1:0] cap;
    docked   = (pmode == MODE_DOCKED);
    official = (pmode == MODE_OFFICIAL);
    charging = (pmode == MODE_CHARGING) || (pmode == MODE_USB) || official;
    cap      = newer ? GPU_CAP_NEW_MHZ : GPU_CAP_OLD_MHZ;
    t.cpu    = CPU_STOCK_MHZ;
    t.gpu    = GPU_STOCK_MHZ;
    t.mem    = MEM_FULL_MHZ;
    unique case (prof)
      PROF_STOCK: begin
        t.cpu = CPU_STOCK_MHZ;
        t.gpu = docked ? GPU_DOCK_MHZ : GPU_STOCK_MHZ;
        t.mem = docked ? MEM_FULL_MHZ : MEM_STOCK_MHZ;
      end
      PROF_BALANCED: begin
        t.cpu = (docked || charging) ? CPU_1428_MHZ : CPU_1224_MHZ;
        t.gpu = docked ? GPU_BAL_DOCK_MHZ : cap;
      end
      PROF_PERF: begin
        t.cpu = (docked || charging) ? CPU_1581_MHZ : CPU_1428_MHZ;
        t.gpu = (docked || official) ? GPU_DOCK_MHZ : cap;
      end
      PROF_MAX: begin
        t.cpu = CPU_1785_MHZ;
        t.gpu = (docked || official) ? GPU_DOCK_MHZ : cap;
      end
      default: begin
        t.cpu = CPU_STOCK_MHZ;
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tcpg_regs.sv =====
`default_nettype none

module tcpg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcpg_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tcpg_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcpg_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output tcpg_pkg::cfg_t                     cfg_o
);
  import tcpg_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PROFILE:     cfg_d.profile_select     = pwdata[1:0];
        REG_NEWER_CHIP:  cfg_d.newer_chip         = pwdata[0];
        REG_GUARD_ENTER: cfg_d.guard_enter_millic = pwdata[TEMP_W-1:0];
        REG_GUARD_EXIT:  cfg_d.guard_exit_millic  = pwdata[TEMP_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROFILE:     prdata = {30'd0, cfg_q.profile_select};
      REG_NEWER_CHIP:  prdata = {31'd0, cfg_q.newer_chip};
      REG_GUARD_ENTER: prdata = {14'd0, cfg_q.guard_enter_millic};
      REG_GUARD_EXIT:  prdata = {14'd0, cfg_q.guard_exit_millic};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.profile_select     <= PROF_STOCK;
      cfg_q.newer_chip         <= 1'b0;
      cfg_q.guard_enter_millic <= GUARD_ENTER_RST;
      cfg_q.guard_exit_millic  <= GUARD_EXIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/tcpg_step.sv =====
`default_nettype none

module tcpg_step (
  input  wire tcpg_pkg::cfg_t     cfg_i,
  input  wire tcpg_pkg::tcpg_in_t item_i,
  input  wire tcpg_pkg::state_t   state_i,
  output tcpg_pkg::tcpg_out_t res_o,
  output tcpg_pkg::state_t   state_o
);
  import tcpg_pkg::*;

  logic [2:0]        pmode;
  logic [TEMP_W-1:0] max_sb;
  logic [TEMP_W-1:0] hottest;
  logic              enter_hit;
  logic              exit_hit;
  logic              guard_n;
  logic [NUM_MOD-1:0][MHZ_W-1:0] applied_base;
  logic [NUM_MOD-1:0][MHZ_W-1:0] applied_n;
  logic [NUM_MOD-1:0][MHZ_W-1:0] tgt;
  logic [2:0]        wmask;
  logic              failed;
  mhz_t              pick;
  status_e           status;

  // undefined modes act as handheld
  assign pmode   = (item_i.power_mode > MODE_DOCKED) ? MODE_HANDHELD : item_i.power_mode;
  assign max_sb  = (item_i.temp_board > item_i.temp_soc) ? item_i.temp_board : item_i.temp_soc;
  assign hottest = (item_i.temp_skin > max_sb) ? item_i.temp_skin : max_sb;

  assign enter_hit = !state_i.guard_flag && (hottest >= cfg_i.guard_enter_millic);
  assign exit_hit  = state_i.guard_flag && (hottest <= cfg_i.guard_exit_millic);
  assign guard_n   = enter_hit ? 1'b1 : (exit_hit ? 1'b0 : state_i.guard_flag);

  // a guard change forgets what was applied
  assign applied_base = (enter_hit || exit_hit) ? '0 : state_i.applied_mhz;

  assign pick = pick_targets(guard_n ? PROF_STOCK : cfg_i.profile_select, pmode,
                             cfg_i.newer_chip);
  assign tgt[0] = pick.cpu;
  assign tgt[1] = {{(MHZ_W-GPU_W){1'b0}}, pick.gpu};
  assign tgt[2] = pick.mem;

  always_comb begin
    wmask     = '0;
    failed    = 1'b0;
    applied_n = applied_base;
    for (int i = 0; i < NUM_MOD; i++) begin
      if (applied_base[i] != tgt[i]) begin
        wmask[i] = 1'b1;
        if (item_i.fail_mask[i]) begin
          failed = 1'b1;
        end else begin
          applied_n[i] = tgt[i];
        end
      end
    end
  end

  always_comb begin
    priority if (failed)    status = ST_WRITE_FAIL;
    else if (enter_hit)     status = ST_GUARD_ENTER;
    else if (exit_hit)      status = ST_RECOVERED;
    else                    status = ST_NONE;
  end

  always_comb begin
    if (!item_i.link_ok) begin
      res_o              = '0;
      res_o.guard_active = state_i.guard_flag;
      res_o.status_code  = ST_LINK_LOST;
      state_o            = state_i;
    end else begin
      res_o.cpu_target_mhz = pick.cpu;
      res_o.gpu_target_mhz = pick.gpu;
      res_o.mem_target_mhz = pick.mem;
      res_o.write_mask     = wmask;
      res_o.guard_active   = guard_n;
      res_o.hottest_millic = hottest;
      res_o.status_code    = status;
      state_o.guard_flag   = guard_n;
      state_o.applied_mhz  = applied_n;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/thermal_clock_profile_governor.sv =====
`default_nettype none

// thermal clock profile governor: one update tick in, one result out. Each tick takes the
// hottest of three sensors, runs a hysteresis guard against the enter and exit thresholds,
// looks up cpu/gpu/mem clock targets for the profile, power mode and chip variant (stock
// clocks while the guard is set) and flags a write for every module whose target differs
// from its applied clock. A module's applied clock follows its target only when its write
// does not fail; a guard change forgets all applied clocks. With link_ok low the state
// holds and the result carries status "link lost". Throughput is one transaction per clock
// while the result is not stalled. Each accepted input passes through the input register, then the
// combinational step logic into the result register, where the guard and applied clocks are
// updated too, and the input stalls only while both registers are full and the result is
// stalled. Configuration over apb: 0x0 profile, 0x4 chip variant, 0x8 enter
// threshold, 0xC exit threshold; write only while no transaction is in flight.

module thermal_clock_profile_governor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tcpg_pkg::tcpg_in_t            in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tcpg_pkg::tcpg_out_t                out_data_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tcpg_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tcpg_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcpg_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import tcpg_pkg::*;

  cfg_t      cfg;
  logic      in_valid_q;
  tcpg_in_t  in_q;
  logic      out_valid_q, out_valid_d;
  tcpg_out_t out_q;
  state_t    state_q, state_d;
  tcpg_out_t res;
  logic      out_blocked;
  logic      advance;
  logic      in_take;

  tcpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcpg_step u_step (
    .cfg_i   (cfg),
    .item_i  (in_q),
    .state_i (state_q),
    .res_o   (res),
    .state_o (state_d)
  );

  // result register still holds an untaken transaction
  assign out_blocked = out_valid_q && out_stall_i;
  // staged tick moves into the result register and commits its state update
  assign advance     = in_valid_q && !out_blocked;
  // input register frees up whenever its tick advances
  assign in_stall_o  = in_valid_q && out_blocked;
  assign in_take     = in_valid_i && !in_stall_o;

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state and the guard / applied clocks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // stall only with both stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  // lost link shows no cpu clock, no writes and no temperature
  a_link_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status_code == ST_LINK_LOST) |->
      (out_data_o.write_mask == 3'd0 && out_data_o.hottest_millic == '0
       && out_data_o.cpu_target_mhz == '0))
    else $error("link lost result carries data");

  // guard status codes agree with the reported guard
  a_guard_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status_code == ST_GUARD_ENTER
                     || out_data_o.status_code == ST_RECOVERED)) |->
      (out_data_o.guard_active == (out_data_o.status_code == ST_GUARD_ENTER)))
    else $error("guard status disagrees with guard state");

  // a failed write needs an issued write
  a_fail_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status_code == ST_WRITE_FAIL) |->
      (out_data_o.write_mask != 3'd0))
    else $error("write failure without a write");

  // committed guard matches the last result delivered into the output register
  a_guard_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) |-> (state_q.guard_flag == out_q.guard_active))
    else $error("guard state and result diverge");

endmodule

`default_nettype wire
